// ===== sv/cmts_pkg.sv =====
// token kinds, error codes and keyword tables shared by the c-minus token scanner
package cmts_pkg;

	localparam int KIND_W = 5;
	localparam int ERR_W  = 2;
	localparam int LEN_W  = 7;

	localparam logic [KIND_W-1:0] K_ID       = 5'd0;
	localparam logic [KIND_W-1:0] K_NUM      = 5'd1;
	localparam logic [KIND_W-1:0] K_PLUS     = 5'd2;
	localparam logic [KIND_W-1:0] K_MINUS    = 5'd3;
	localparam logic [KIND_W-1:0] K_TIMES    = 5'd4;
	localparam logic [KIND_W-1:0] K_OVER     = 5'd5;
	localparam logic [KIND_W-1:0] K_LT       = 5'd6;
	localparam logic [KIND_W-1:0] K_LEQ      = 5'd7;
	localparam logic [KIND_W-1:0] K_GT       = 5'd8;
	localparam logic [KIND_W-1:0] K_GEQ      = 5'd9;
	localparam logic [KIND_W-1:0] K_EQ       = 5'd10;
	localparam logic [KIND_W-1:0] K_NEQ      = 5'd11;
	localparam logic [KIND_W-1:0] K_ASSIGN   = 5'd12;
	localparam logic [KIND_W-1:0] K_SEMI     = 5'd14;
	localparam logic [KIND_W-1:0] K_COMMA    = 5'd15;
	localparam logic [KIND_W-1:0] K_LPAREN   = 5'd16;
	localparam logic [KIND_W-1:0] K_RPAREN   = 5'd17;
	localparam logic [KIND_W-1:0] K_LBRACE   = 5'd18;
	localparam logic [KIND_W-1:0] K_RBRACE   = 5'd19;
	localparam logic [KIND_W-1:0] K_LBRACKET = 5'd20;
	localparam logic [KIND_W-1:0] K_RBRACKET = 5'd21;
	localparam logic [KIND_W-1:0] K_KW0      = 5'd22;
	localparam logic [KIND_W-1:0] K_ERROR    = 5'd28;

	localparam logic [ERR_W-1:0] E_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] E_ILLEGAL  = 2'd1;
	localparam logic [ERR_W-1:0] E_BADNUM   = 2'd2;
	localparam logic [ERR_W-1:0] E_UNCLOSED = 2'd3;

	localparam int NUM_KW = 6;

	// if, else, while, int, return, void; padded so any 3-bit index is safe
	localparam logic [7:0] KW_TEXT [0:NUM_KW-1][0:7] = '{
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
		'{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [0:NUM_KW-1] = '{3'd2, 3'd4, 3'd5, 3'd3, 3'd6, 3'd4};

	// drop keywords that cannot match once character c sits at offset len
	function automatic logic [NUM_KW-1:0] kw_update(input logic [NUM_KW-1:0] mask,
			input logic [LEN_W-1:0] len, input logic [7:0] c);
		logic [NUM_KW-1:0] m;
		logic hit;
		m = mask;
		for (int k = 0; k < NUM_KW; k++) begin
			hit = (len < {4'd0, KW_LEN[k]}) && (KW_TEXT[k][len[2:0]] == c);
			if (!hit)
				m[k] = 1'b0;
		end
		return m;
	endfunction

	function automatic logic [KIND_W-1:0] word_kind(input logic [NUM_KW-1:0] mask,
			input logic [LEN_W-1:0] len);
		logic [KIND_W-1:0] kind;
		kind = K_ID;
		for (int k = 0; k < NUM_KW; k++) begin
			if (mask[k] && len == {4'd0, KW_LEN[k]})
				kind = K_KW0 + KIND_W'(k);
		end
		return kind;
	endfunction

	// operator character held back for lookahead, standing alone
	function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] p);
		logic [KIND_W-1:0] kind;
		case (p)
			"+": kind = K_PLUS;
			"-": kind = K_MINUS;
			"=": kind = K_ASSIGN;
			"<": kind = K_LT;
			">": kind = K_GT;
			"/": kind = K_OVER;
			default: kind = K_ERROR;
		endcase
		return kind;
	endfunction

endpackage

// ===== sv/c_minus_token_scanner.sv =====
// top level of the c-minus token scanner: scan state, token builder and output queue
//
// Takes one source byte per word on the input channel and emits classified token
// words on the output channel, each carrying kind, error code, start line/column
// and length. Every byte is fully processed in the cycle it is accepted: the scan
// state registers are updated from short logic on the byte and the old state, and
// the zero, one or two token words the byte causes are written into a four-word
// output queue in the same edge. A byte is taken every cycle while the queue holds
// two words or fewer; the single read port of the output queue delivers one token
// word per clock while out_ready is high, so bytes that yield two tokens (a token
// ended by a one-character token, or a flush followed by end-of-file) can fill the
// queue and hold the input back. The end flag or a zero byte flushes any open token,
// emits the end-of-file word and returns the scanner to line 1 column 1.
// There is no configuration and no clearing pass after reset.
module c_minus_token_scanner #(
	parameter int MAX_TOKEN_LEN = 64,
	parameter int POSITION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    ch,
	input  logic                          is_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cmts_pkg::KIND_W-1:0]   token_kind,
	output logic [cmts_pkg::ERR_W-1:0]    error_code,
	output logic [POSITION_BITS-1:0]      start_line,
	output logic [POSITION_BITS-1:0]      start_column,
	output logic [cmts_pkg::LEN_W-1:0]    token_length,
	output logic                          is_end_token,
	output logic                          is_last
);

	import cmts_pkg::*;

	// scan modes
	localparam logic [2:0] M_IDLE      = 3'd0;
	localparam logic [2:0] M_IDENT     = 3'd1;
	localparam logic [2:0] M_NUMBER    = 3'd2;
	localparam logic [2:0] M_PENDING   = 3'd3;
	localparam logic [2:0] M_LINECOM   = 3'd4;
	localparam logic [2:0] M_BLOCK     = 3'd5;
	localparam logic [2:0] M_BLOCKSTAR = 3'd6;

	localparam logic [LEN_W-1:0]         MAX_LEN = LEN_W'(MAX_TOKEN_LEN);
	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic [ERR_W-1:0]         err;
		logic [POSITION_BITS-1:0] line;
		logic [POSITION_BITS-1:0] col;
		logic [LEN_W-1:0]         len;
		logic                     eof;
		logic                     last;
	} tok_t;

	// scan state
	logic [2:0]               mode_q, mode_d;
	logic [7:0]               pend_q, pend_d;
	logic [NUM_KW-1:0]        kw_q, kw_d;
	logic                     bad_q, bad_d;
	logic [LEN_W-1:0]         len_q, len_d;
	logic [POSITION_BITS-1:0] tline_q, tline_d, tcol_q, tcol_d;
	logic [POSITION_BITS-1:0] line_q, line_d, col_q, col_d;

	// output queue
	tok_t       fifo_q [0:3];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] cnt_q;

	logic in_fire, out_fire;
	logic end_in, letter, digit, alnum;
	logic [LEN_W-1:0] grown_len;

	// what a byte does when it starts a fresh token
	logic             use_fresh, f_emit, f_begin;
	logic [2:0]       f_mode;
	logic [KIND_W-1:0] f_kind;
	logic [ERR_W-1:0]  f_err;

	// slot a: token closed by this byte, slot b: fresh single token or end-of-file
	logic              a_v, b_v, b_eof;
	logic [KIND_W-1:0] a_kind;
	logic [ERR_W-1:0]  a_err;
	logic [LEN_W-1:0]  a_len;
	tok_t              a_tok, b_tok, slot0, slot1;
	logic [1:0]        push_n;

	assign in_ready  = (cnt_q <= 3'd2);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = (cnt_q != 3'd0);
	assign out_fire  = out_valid && out_ready;

	always_comb begin
		end_in    = is_end || (ch == 8'h00);
		letter    = (ch inside {["a":"z"], ["A":"Z"], "_"});
		digit     = (ch inside {["0":"9"]});
		alnum     = letter || digit;
		grown_len = (len_q < MAX_LEN) ? len_q + LEN_W'(1) : len_q;

		// classify the byte as a token opener
		f_mode  = M_IDLE;
		f_emit  = 1'b0;
		f_begin = 1'b0;
		f_kind  = K_ERROR;
		f_err   = E_NONE;
		if (ch inside {" ", 8'h09, 8'h0D, 8'h0A}) begin
			f_mode = M_IDLE;
		end else if (ch == "#") begin
			f_mode = M_LINECOM;
		end else if (letter) begin
			f_mode  = M_IDENT;
			f_begin = 1'b1;
		end else if (digit) begin
			f_mode  = M_NUMBER;
			f_begin = 1'b1;
		end else if (ch inside {"+", "-", "=", "!", "<", ">", "|", "&", "/"}) begin
			f_mode  = M_PENDING;
			f_begin = 1'b1;
		end else begin
			f_emit = 1'b1;
			case (ch)
				"*": f_kind = K_TIMES;
				";": f_kind = K_SEMI;
				",": f_kind = K_COMMA;
				"(": f_kind = K_LPAREN;
				")": f_kind = K_RPAREN;
				"{": f_kind = K_LBRACE;
				"}": f_kind = K_RBRACE;
				"[": f_kind = K_LBRACKET;
				"]": f_kind = K_RBRACKET;
				"^", "%", "?", "~", ":", "\"", "\\": f_kind = K_ERROR;
				default: begin
					f_kind = K_ERROR;
					f_err  = E_ILLEGAL;
				end
			endcase
		end

		mode_d  = mode_q;
		pend_d  = pend_q;
		kw_d    = kw_q;
		bad_d   = bad_q;
		len_d   = len_q;
		tline_d = tline_q;
		tcol_d  = tcol_q;
		line_d  = line_q;
		col_d   = col_q;

		a_v       = 1'b0;
		a_kind    = K_ID;
		a_err     = E_NONE;
		a_len     = len_q;
		use_fresh = 1'b0;
		b_eof     = 1'b0;

		if (end_in) begin
			// flush the open token, then end-of-file and back to reset state
			case (mode_q)
				M_IDENT: begin
					a_v    = 1'b1;
					a_kind = word_kind(kw_q, len_q);
				end
				M_NUMBER: begin
					a_v    = 1'b1;
					a_kind = bad_q ? K_ERROR : K_NUM;
					a_err  = bad_q ? E_BADNUM : E_NONE;
				end
				M_PENDING: begin
					a_v    = 1'b1;
					a_kind = single_kind(pend_q);
				end
				M_BLOCK, M_BLOCKSTAR: begin
					a_v    = 1'b1;
					a_kind = K_ERROR;
					a_err  = E_UNCLOSED;
				end
				default: ;
			endcase
			b_eof   = 1'b1;
			mode_d  = M_IDLE;
			pend_d  = 8'h00;
			kw_d    = {NUM_KW{1'b1}};
			bad_d   = 1'b0;
			len_d   = '0;
			tline_d = POS_ONE;
			tcol_d  = POS_ONE;
			line_d  = POS_ONE;
			col_d   = POS_ONE;
		end else begin
			case (mode_q)
				M_IDENT: begin
					if (alnum) begin
						kw_d  = kw_update(kw_q, len_q, ch);
						len_d = grown_len;
					end else begin
						a_v       = 1'b1;
						a_kind    = word_kind(kw_q, len_q);
						use_fresh = 1'b1;
					end
				end
				M_NUMBER: begin
					if (alnum) begin
						bad_d = bad_q || letter;
						len_d = grown_len;
					end else begin
						a_v       = 1'b1;
						a_kind    = bad_q ? K_ERROR : K_NUM;
						a_err     = bad_q ? E_BADNUM : E_NONE;
						use_fresh = 1'b1;
					end
				end
				M_PENDING: begin
					if (pend_q == "/" && ch == "/") begin
						mode_d = M_LINECOM;
					end else if (pend_q == "/" && ch == "*") begin
						len_d  = grown_len;
						mode_d = M_BLOCK;
					end else if (ch == "=" && (pend_q inside {"=", "!", "<", ">"})) begin
						// two-character relational operator
						a_v    = 1'b1;
						a_len  = grown_len;
						len_d  = grown_len;
						mode_d = M_IDLE;
						case (pend_q)
							"=": a_kind = K_EQ;
							"!": a_kind = K_NEQ;
							"<": a_kind = K_LEQ;
							default: a_kind = K_GEQ;
						endcase
					end else if (ch == pend_q &&
							(pend_q inside {"+", "-", "<", ">", "|", "&"})) begin
						// doubled operator outside the language
						a_v    = 1'b1;
						a_kind = K_ERROR;
						a_len  = grown_len;
						len_d  = grown_len;
						mode_d = M_IDLE;
					end else begin
						a_v       = 1'b1;
						a_kind    = single_kind(pend_q);
						use_fresh = 1'b1;
					end
				end
				M_LINECOM: begin
					if (ch == 8'h0A)
						mode_d = M_IDLE;
				end
				M_BLOCK: begin
					len_d = grown_len;
					if (ch == "*")
						mode_d = M_BLOCKSTAR;
				end
				M_BLOCKSTAR: begin
					len_d = grown_len;
					if (ch == "/")
						mode_d = M_IDLE;
					else if (ch != "*")
						mode_d = M_BLOCK;
				end
				default: begin
					use_fresh = 1'b1;
				end
			endcase

			if (use_fresh) begin
				mode_d = f_mode;
				if (f_begin) begin
					tline_d = line_q;
					tcol_d  = col_q;
					len_d   = LEN_W'(1);
					if (letter)
						kw_d = kw_update({NUM_KW{1'b1}}, '0, ch);
					if (digit)
						bad_d = 1'b0;
					if (f_mode == M_PENDING)
						pend_d = ch;
				end
			end

			// position of the next byte
			if (ch == 8'h0A) begin
				if (line_q < POS_MAX)
					line_d = line_q + POS_ONE;
				col_d = POS_ONE;
			end else if (col_q < POS_MAX) begin
				col_d = col_q + POS_ONE;
			end
		end

		a_tok = '{kind: a_kind, err: a_err, line: tline_q, col: tcol_q, len: a_len,
			eof: 1'b0, last: 1'b0};
		b_v = b_eof || (use_fresh && f_emit);
		if (b_eof)
			b_tok = '{kind: K_ID, err: E_NONE, line: line_q, col: col_q, len: '0,
				eof: 1'b1, last: 1'b1};
		else
			b_tok = '{kind: f_kind, err: f_err, line: line_q, col: col_q,
				len: LEN_W'(1), eof: 1'b0, last: 1'b1};

		slot0      = a_v ? a_tok : b_tok;
		slot0.last = !(a_v && b_v);
		slot1      = b_tok;
		push_n     = {1'b0, a_v} + {1'b0, b_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pend_q  <= 8'h00;
			kw_q    <= {NUM_KW{1'b1}};
			bad_q   <= 1'b0;
			len_q   <= '0;
			tline_q <= POS_ONE;
			tcol_q  <= POS_ONE;
			line_q  <= POS_ONE;
			col_q   <= POS_ONE;
		end else if (in_fire) begin
			mode_q  <= mode_d;
			pend_q  <= pend_d;
			kw_q    <= kw_d;
			bad_q   <= bad_d;
			len_q   <= len_d;
			tline_q <= tline_d;
			tcol_q  <= tcol_d;
			line_q  <= line_d;
			col_q   <= col_d;
		end
	end

	// queue payload, no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (push_n != 2'd0)
				fifo_q[wr_ptr_q] <= slot0;
			if (push_n == 2'd2)
				fifo_q[wr_ptr_q + 2'd1] <= slot1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			if (in_fire)
				wr_ptr_q <= wr_ptr_q + push_n;
			if (out_fire)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + (in_fire ? {1'b0, push_n} : 3'd0) - {2'b00, out_fire};
		end
	end

	assign token_kind   = fifo_q[rd_ptr_q].kind;
	assign error_code   = fifo_q[rd_ptr_q].err;
	assign start_line   = fifo_q[rd_ptr_q].line;
	assign start_column = fifo_q[rd_ptr_q].col;
	assign token_length = fifo_q[rd_ptr_q].len;
	assign is_end_token = fifo_q[rd_ptr_q].eof;
	assign is_last      = fifo_q[rd_ptr_q].last;

	// queue never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("output queue count out of range");

	// end of input puts the scanner back at the start of a text
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && end_in |=> mode_q == M_IDLE && line_q == POS_ONE && col_q == POS_ONE)
		else $error("scan state not reset after end of input");

	// lengths saturate
	a_len_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_length <= MAX_LEN)
		else $error("token length above maximum");

	// end-of-file word is empty and closes its byte
	a_eof_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_end_token |-> token_kind == K_ID && token_length == '0 && is_last)
		else $error("malformed end-of-file word");

endmodule

// ===== verif/tb_c_minus_token_scanner.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the c-minus token scanner: directed table, long comment, random text
module tb_c_minus_token_scanner;
	import cmts_pkg::*;

	localparam int MAX_LEN     = 64;
	localparam int POS_BITS    = 16;
	localparam int LIMIT       = 200000;
	localparam int PHASE_BYTES = 250;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	typedef logic [POS_BITS-1:0] pos_t;

	// one token word as it leaves the block
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ERR_W-1:0]  err;
		pos_t              line;
		pos_t              col;
		logic [LEN_W-1:0]  len;
		logic              eof;
		logic              last;
	} tok_t;

	// one input byte word, optionally with its token words typed in by hand
	typedef struct {
		logic [7:0] c;
		logic       eoi;
		logic       typed;
		int         n;
		tok_t       t0;
		tok_t       t1;
	} stim_row_t;

	typedef enum logic [2:0] {
		SM_IDLE,
		SM_WORD,
		SM_NUMBER,
		SM_OP_HELD,
		SM_LINE_CMT,
		SM_BLOCK_CMT,
		SM_BLOCK_STAR
	} scan_mode_e;

	localparam tok_t NO_TOK = '0;

	// dut ports
	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic [7:0]        ch        = 8'h00;
	logic              is_end    = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [KIND_W-1:0] token_kind;
	logic [ERR_W-1:0]  error_code;
	pos_t              start_line;
	pos_t              start_column;
	logic [LEN_W-1:0]  token_length;
	logic              is_end_token;
	logic              is_last;

	// shadow scanner state
	scan_mode_e        mode;
	logic [7:0]        held_ch;
	logic [NUM_KW-1:0] kw_live;
	logic              num_bad;
	logic [LEN_W-1:0]  tlen;
	pos_t              tok_line;
	pos_t              tok_col;
	pos_t              cur_line;
	pos_t              cur_col;

	string kw_word [0:5] = '{"if", "else", "while", "int", "return", "void"};
	string op_text [0:26] = '{"+", "-", "*", "/", "<", "<=", ">", ">=", "==", "!=", "=", "!",
		"++", "--", "<<", ">>", "||", "&&", "|", "&", "^", "%", "?", "~", ":", "\"", "\\"};
	string punct_text = "();,[]{}*";

	tok_t      step_toks [$];
	tok_t      expected_tokens [$];
	stim_row_t dir_tab [$];

	tok_t got_tok;
	tok_t want_tok;

	int idle_pct      = 0;
	int stall_pct     = 0;
	int bytes_sent    = 0;
	int words_checked = 0;
	int eof_seen      = 0;
	int err_seen      = 0;
	int n_fail        = 0;
	int cycle_cnt     = 0;

	c_minus_token_scanner #(
		.MAX_TOKEN_LEN(MAX_LEN),
		.POSITION_BITS(POS_BITS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.ch          (ch),
		.is_end      (is_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.token_kind  (token_kind),
		.error_code  (error_code),
		.start_line  (start_line),
		.start_column(start_column),
		.token_length(token_length),
		.is_end_token(is_end_token),
		.is_last     (is_last)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// ---------------------------------------------------------------
	// shadow scanner: predicts the token words of one input byte
	// ---------------------------------------------------------------

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic tok_t tk(input logic [KIND_W-1:0] kind, input logic [ERR_W-1:0] err,
			input pos_t line, input pos_t col, input logic [LEN_W-1:0] len, input logic eof);
		return '{kind, err, line, col, len, eof, 1'b0};
	endfunction

	task automatic scanner_reset();
		mode     = SM_IDLE;
		held_ch  = 8'h00;
		kw_live  = '1;
		num_bad  = 1'b0;
		tlen     = '0;
		tok_line = 1;
		tok_col  = 1;
		cur_line = 1;
		cur_col  = 1;
	endtask

	// token that started earlier, at the saved position
	task automatic push_tok(input logic [KIND_W-1:0] kind, input logic [ERR_W-1:0] err);
		step_toks.push_back(tk(kind, err, tok_line, tok_col, tlen, 1'b0));
	endtask

	task automatic grow_len();
		if (tlen < MAX_LEN)
			tlen++;
	endtask

	// knock out keywords that the byte at offset tlen rules out
	task automatic drop_keywords(input logic [7:0] c);
		for (int k = 0; k < NUM_KW; k++) begin
			if (kw_live[k] && (tlen >= kw_word[k].len() || kw_word[k][tlen] != c))
				kw_live[k] = 1'b0;
		end
	endtask

	task automatic open_token(input scan_mode_e m);
		mode     = m;
		tok_line = cur_line;
		tok_col  = cur_col;
		tlen     = 1;
	endtask

	task automatic close_word();
		logic [KIND_W-1:0] kind;
		kind = K_ID;
		for (int k = 0; k < NUM_KW; k++) begin
			if (kw_live[k] && tlen == kw_word[k].len())
				kind = K_KW0 + KIND_W'(k);
		end
		mode = SM_IDLE;
		push_tok(kind, E_NONE);
	endtask

	task automatic close_number();
		push_tok(num_bad ? K_ERROR : K_NUM, num_bad ? E_BADNUM : E_NONE);
	endtask

	task automatic close_held();
		logic [KIND_W-1:0] kind;
		case (held_ch)
			"+": kind = K_PLUS;
			"-": kind = K_MINUS;
			"=": kind = K_ASSIGN;
			"<": kind = K_LT;
			">": kind = K_GT;
			"/": kind = K_OVER;
			default: kind = K_ERROR;
		endcase
		mode = SM_IDLE;
		push_tok(kind, E_NONE);
	endtask

	// byte seen with no token open
	task automatic start_token(input logic [7:0] c);
		logic [KIND_W-1:0] kind;
		logic [ERR_W-1:0]  err;
		err = E_NONE;
		kind = K_ERROR;
		if (c == " " || c == CH_TAB || c == CH_CR || c == CH_LF)
			return;
		if (c == "#") begin
			mode = SM_LINE_CMT;
			return;
		end
		if (is_letter(c)) begin
			open_token(SM_WORD);
			kw_live = '1;
			tlen = 0;
			drop_keywords(c);
			tlen = 1;
			return;
		end
		if (is_digit(c)) begin
			open_token(SM_NUMBER);
			num_bad = 1'b0;
			return;
		end
		case (c)
			"+", "-", "=", "!", "<", ">", "|", "&", "/": begin
				open_token(SM_OP_HELD);
				held_ch = c;
				return;
			end
			"*": kind = K_TIMES;
			";": kind = K_SEMI;
			",": kind = K_COMMA;
			"(": kind = K_LPAREN;
			")": kind = K_RPAREN;
			"{": kind = K_LBRACE;
			"}": kind = K_RBRACE;
			"[": kind = K_LBRACKET;
			"]": kind = K_RBRACKET;
			// operators outside the language: error kind without a code
			"^", "%", "?", "~", ":", "\"", "\\": kind = K_ERROR;
			default: begin
				kind = K_ERROR;
				err  = E_ILLEGAL;
			end
		endcase
		step_toks.push_back(tk(kind, err, cur_line, cur_col, 1, 1'b0));
	endtask

	// lookahead byte after a held operator character
	task automatic follow_held(input logic [7:0] c);
		logic [KIND_W-1:0] kind;
		logic              pair;
		pair = 1'b0;
		kind = K_ERROR;
		if (held_ch == "/" && c == "/") begin
			mode = SM_LINE_CMT;
			return;
		end
		if (held_ch == "/" && c == "*") begin
			grow_len();
			mode = SM_BLOCK_CMT;
			return;
		end
		if (c == "=" && (held_ch == "=" || held_ch == "!" || held_ch == "<" || held_ch == ">")) begin
			pair = 1'b1;
			case (held_ch)
				"=": kind = K_EQ;
				"!": kind = K_NEQ;
				"<": kind = K_LEQ;
				default: kind = K_GEQ;
			endcase
		end else if (c == held_ch && (c == "+" || c == "-" || c == "<" || c == ">" ||
				c == "|" || c == "&")) begin
			pair = 1'b1;
			kind = K_ERROR;
		end
		if (pair) begin
			grow_len();
			mode = SM_IDLE;
			push_tok(kind, E_NONE);
		end else begin
			close_held();
			start_token(c);
		end
	endtask

	task automatic scan_byte(input logic [7:0] c, input logic eoi);
		step_toks.delete();
		if (eoi || c == CH_NUL) begin
			case (mode)
				SM_WORD:       close_word();
				SM_NUMBER:     close_number();
				SM_OP_HELD:    close_held();
				SM_BLOCK_CMT,
				SM_BLOCK_STAR: push_tok(K_ERROR, E_UNCLOSED);
				default: ;
			endcase
			step_toks.push_back(tk(K_ID, E_NONE, cur_line, cur_col, 0, 1'b1));
			scanner_reset();
		end else begin
			case (mode)
				SM_WORD: begin
					if (is_letter(c) || is_digit(c)) begin
						drop_keywords(c);
						grow_len();
					end else begin
						close_word();
						start_token(c);
					end
				end
				SM_NUMBER: begin
					if (is_letter(c) || is_digit(c)) begin
						if (is_letter(c))
							num_bad = 1'b1;
						grow_len();
					end else begin
						close_number();
						mode = SM_IDLE;
						start_token(c);
					end
				end
				SM_OP_HELD:  follow_held(c);
				SM_LINE_CMT: if (c == CH_LF) mode = SM_IDLE;
				SM_BLOCK_CMT: begin
					grow_len();
					if (c == "*")
						mode = SM_BLOCK_STAR;
				end
				SM_BLOCK_STAR: begin
					grow_len();
					if (c == "/")
						mode = SM_IDLE;
					else if (c != "*")
						mode = SM_BLOCK_CMT;
				end
				default: begin
					mode = SM_IDLE;
					start_token(c);
				end
			endcase
			// position of the next byte, saturating
			if (c == CH_LF) begin
				if (cur_line != '1)
					cur_line++;
				cur_col = 1;
			end else if (cur_col != '1) begin
				cur_col++;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// input side
	// ---------------------------------------------------------------

	function automatic stim_row_t given(input logic [7:0] c, input logic eoi, input int n,
			input tok_t t0, input tok_t t1);
		stim_row_t r;
		r.c = c;
		r.eoi = eoi;
		r.typed = 1'b1;
		r.n = n;
		r.t0 = t0;
		r.t1 = t1;
		return r;
	endfunction

	function automatic stim_row_t free_row(input logic [7:0] c, input logic eoi);
		stim_row_t r;
		r = given(c, eoi, 0, NO_TOK, NO_TOK);
		r.typed = 1'b0;
		return r;
	endfunction

	// one byte word: hold it until taken, queue its tokens, then maybe go idle
	task automatic send_byte(input stim_row_t row);
		tok_t t;
		in_valid <= 1'b1;
		ch       <= row.c;
		is_end   <= row.eoi;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
		scan_byte(row.c, row.eoi);
		if (row.typed) begin
			step_toks.delete();
			if (row.n > 0)
				step_toks.push_back(row.t0);
			if (row.n > 1)
				step_toks.push_back(row.t1);
		end
		if (step_toks.size() > 0) begin
			t = step_toks.pop_back();
			t.last = 1'b1;
			step_toks.push_back(t);
		end
		foreach (step_toks[i])
			expected_tokens.push_back(step_toks[i]);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			ch       <= 8'($urandom);
			is_end   <= 1'($urandom);
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic put_ch(input logic [7:0] c);
		send_byte(free_row(c, 1'b0));
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			put_ch(s[i]);
	endtask

	// letter, '_' or (when not leading) digit
	function automatic logic [7:0] word_char(input logic lead);
		int r;
		r = $urandom_range(lead ? 52 : 62, 0);
		if (r < 26)
			return 8'("a" + r);
		if (r < 52)
			return 8'("A" + r - 26);
		if (r == 52)
			return "_";
		return 8'("0" + r - 53);
	endfunction

	// mostly well-formed c-minus text with random content, some noise and broken pieces
	task automatic send_fragment();
		int         pick;
		int         n;
		int         bad_at;
		string      w;
		logic [7:0] c;
		pick = $urandom_range(99);
		if (pick < 15) begin
			// keywords and near misses
			w = kw_word[$urandom_range(5)];
			case ($urandom_range(3))
				0: send_str(w);
				1: begin
					send_str(w);
					put_ch(word_char(1'b0));
				end
				2: send_str(w.substr(0, w.len() - 2));
				default: begin
					put_ch(w[0] - 8'd32);
					send_str(w.substr(1, w.len() - 1));
				end
			endcase
		end else if (pick < 30) begin
			n = ($urandom_range(99) < 4) ? $urandom_range(72, 60) : $urandom_range(8, 1);
			put_ch(word_char(1'b1));
			repeat (n - 1)
				put_ch(word_char(1'b0));
		end else if (pick < 40) begin
			n = $urandom_range(6, 1);
			bad_at = ($urandom_range(3) == 0) ? $urandom_range(n, 1) : 0;
			put_ch(8'("0" + $urandom_range(9)));
			for (int i = 1; i <= n; i++) begin
				if (i == bad_at)
					put_ch(word_char(1'b1));
				else
					put_ch(8'("0" + $urandom_range(9)));
			end
		end else if (pick < 60) begin
			send_str(op_text[$urandom_range(26)]);
		end else if (pick < 70) begin
			put_ch(punct_text[$urandom_range(punct_text.len() - 1)]);
		end else if (pick < 80) begin
			repeat ($urandom_range(3, 1)) begin
				case ($urandom_range(3))
					0: put_ch(" ");
					1: put_ch(CH_TAB);
					2: put_ch(CH_CR);
					default: put_ch(CH_LF);
				endcase
			end
		end else if (pick < 85) begin
			// line comment, either form
			if ($urandom_range(1))
				put_ch("#");
			else
				send_str("//");
			repeat ($urandom_range(10)) begin
				c = 8'($urandom_range(255, 1));
				put_ch(c == CH_LF ? "z" : c);
			end
			put_ch(CH_LF);
		end else if (pick < 90) begin
			// block comment, sometimes left open up to the end of input
			send_str("/*");
			repeat ($urandom_range(12)) begin
				case ($urandom_range(4))
					0: put_ch("*");
					1: put_ch(CH_LF);
					2: put_ch("/");
					3: put_ch("a");
					default: put_ch(8'($urandom_range(255, 1)));
				endcase
			end
			if ($urandom_range(99) < 15)
				send_byte(free_row(8'($urandom), 1'b1));
			else
				send_str("*/");
		end else if (pick < 96) begin
			put_ch(8'($urandom_range(255, 1)));
		end else begin
			// end of input, by flag with any byte or by a zero byte
			if ($urandom_range(1))
				send_byte(free_row(8'($urandom), 1'b1));
			else
				put_ch(CH_NUL);
		end
		if ($urandom_range(1))
			put_ch($urandom_range(1) ? " " : CH_LF);
	endtask

	// ---------------------------------------------------------------
	// output side: token word check and receiver stalls
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_tok = '{token_kind, error_code, start_line, start_column, token_length,
				is_end_token, is_last};
			words_checked++;
			if (is_end_token)
				eof_seen++;
			if (token_kind == K_ERROR)
				err_seen++;
			if (expected_tokens.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("unexpected token word: kind %0d err %0d at %0d:%0d len %0d eof %0b last %0b",
						got_tok.kind, got_tok.err, got_tok.line, got_tok.col, got_tok.len,
						got_tok.eof, got_tok.last);
			end else begin
				want_tok = expected_tokens.pop_front();
				if (got_tok !== want_tok) begin
					n_fail++;
					if (n_fail <= 10) begin
						$display("token word %0d mismatch", words_checked);
						$display("  expected: kind %0d err %0d at %0d:%0d len %0d eof %0b last %0b",
							want_tok.kind, want_tok.err, want_tok.line, want_tok.col,
							want_tok.len, want_tok.eof, want_tok.last);
						$display("  actual:   kind %0d err %0d at %0d:%0d len %0d eof %0b last %0b",
							got_tok.kind, got_tok.err, got_tok.line, got_tok.col,
							got_tok.len, got_tok.eof, got_tok.last);
					end
				end
			end
		end
		if (arst_n)
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog
	initial begin
		while (cycle_cnt < LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d token words still expected", cycle_cnt,
			expected_tokens.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	initial begin
		int start_cnt;

		scanner_reset();

		// directed table; typed rows give their token words outright, the rest are predicted
		// end of input straight after reset, byte ignored
		dir_tab.push_back(given(8'hFF, 1'b1, 1, tk(K_ID, E_NONE, 1, 1, 0, 1'b1), NO_TOK));
		// top byte and a control byte are illegal
		dir_tab.push_back(given(8'hFF, 1'b0, 1, tk(K_ERROR, E_ILLEGAL, 1, 1, 1, 1'b0), NO_TOK));
		dir_tab.push_back(given(8'h01, 1'b0, 1, tk(K_ERROR, E_ILLEGAL, 1, 2, 1, 1'b0), NO_TOK));
		// "9Z;" malformed number closed by a semicolon
		dir_tab.push_back(given("9", 1'b0, 0, NO_TOK, NO_TOK));
		dir_tab.push_back(given("Z", 1'b0, 0, NO_TOK, NO_TOK));
		dir_tab.push_back(given(";", 1'b0, 2, tk(K_ERROR, E_BADNUM, 1, 3, 2, 1'b0),
			tk(K_SEMI, E_NONE, 1, 5, 1, 1'b0)));
		// "++" is outside the language
		dir_tab.push_back(given("+", 1'b0, 0, NO_TOK, NO_TOK));
		dir_tab.push_back(given("+", 1'b0, 1, tk(K_ERROR, E_NONE, 1, 6, 2, 1'b0), NO_TOK));
		dir_tab.push_back(free_row(CH_LF, 1'b0));
		// "/*/" then a zero byte: the opening star does not close, comment left open
		dir_tab.push_back(free_row("/", 1'b0));
		dir_tab.push_back(free_row("*", 1'b0));
		dir_tab.push_back(free_row("/", 1'b0));
		dir_tab.push_back(given(CH_NUL, 1'b0, 2, tk(K_ERROR, E_UNCLOSED, 2, 1, 3, 1'b0),
			tk(K_ID, E_NONE, 2, 4, 0, 1'b1)));
		// new text from line 1: "if[" keyword ended by a bracket
		dir_tab.push_back(free_row("i", 1'b0));
		dir_tab.push_back(free_row("f", 1'b0));
		dir_tab.push_back(free_row("[", 1'b0));
		// "!=" pair
		dir_tab.push_back(free_row("!", 1'b0));
		dir_tab.push_back(free_row("=", 1'b0));
		// hash comment swallows a high byte
		dir_tab.push_back(free_row("#", 1'b0));
		dir_tab.push_back(free_row(8'hA5, 1'b0));
		dir_tab.push_back(free_row(CH_LF, 1'b0));
		dir_tab.push_back(given("^", 1'b0, 1, tk(K_ERROR, E_NONE, 2, 1, 1, 1'b0), NO_TOK));
		// identifier flushed by the end flag
		dir_tab.push_back(free_row("x", 1'b0));
		dir_tab.push_back(free_row(8'h00, 1'b1));

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;

		// no idling while the table and the long comment run
		foreach (dir_tab[i])
			send_byte(dir_tab[i]);

		// an unclosed comment past the length cap
		put_ch("k");
		send_str("/*");
		repeat (70)
			put_ch("x");
		send_byte(free_row("x", 1'b1));

		// random text under four idle/stall mixes, each closed by an end of input
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 88;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 88;
				end
				default: begin
					idle_pct  = 29;
					stall_pct = 29;
				end
			endcase
			start_cnt = bytes_sent;
			while (bytes_sent - start_cnt < PHASE_BYTES)
				send_fragment();
			send_byte(free_row(8'($urandom), 1'b1));
		end
		in_valid <= 1'b0;

		// drain, then give the output queue time to show any stray word
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);

		$display("sent %0d bytes (table, long open comment, random text in four idle/stall mixes)",
			bytes_sent);
		$display("checked %0d token words: %0d end-of-file, %0d error; %0d mismatches",
			words_checked, eof_seen, err_seen, n_fail);
		if (n_fail == 0 && expected_tokens.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
